>>> sv/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg
// Types and constants shared by the timing wheel timeout table.
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int OP_W      = 3;
  localparam int ID_W      = 4;
  localparam int DELAY_W   = 12;
  localparam int SLOTS_W   = 10;
  localparam int NUM_TIMERS_DEF = 16;

  localparam logic [SLOTS_W-1:0] WHEEL_RESET = 10'd600;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_REFRESH = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_TICK    = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  typedef enum logic {
    EVT_ACK    = 1'b0,
    EVT_EXPIRY = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic            event_kind;
    logic [ID_W-1:0] expired_id;
    logic            callback_run;
    logic            present;
    logic            last;
  } evt_t;

  typedef struct packed {
    logic [SLOTS_W-1:0] delay_mod;
    logic [SLOTS_W-1:0] ticks;
  } entry_t;

endpackage

>>> sv/timing_wheel_timeouts.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeouts
// Table of timeout timers addressed by id, with add, refresh, cancel, tick
// and query commands and one result beat per acknowledgement or expiry.
// ----------------------------------------------------------------------------
// One command is handled at a time; cmd_stall is high while it is in work.
// Add runs a 12-step restoring divider for the modulo. Refresh of an active
// timer reads, modifies and writes back its entry in the entry memory.
// Cancel, query and unknown commands go straight to the acknowledgement. A
// tick walks the whole table, reading and updating each active entry, and
// ends with a final beat. Each expiry is one result beat, in ascending id
// order, and a stalled result output holds the walk.
module timing_wheel_timeouts #(
  parameter int NUM_TIMERS = twt_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  twt_pkg::cmd_t              cmd,
  output logic                       evt_valid,
  input  logic                       evt_stall,
  output twt_pkg::evt_t              evt,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [twt_pkg::SLOTS_W-1:0] cfg_data
);
  import twt_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);
  localparam logic [ID_W+2:0] ID_LIMIT = (ID_W + 3)'(NUM_TIMERS);
  localparam logic [3:0] DIV_LAST = 4'(DELAY_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_ACK,
    S_TSCAN,
    S_TUPD,
    S_TEND
  } state_t;

  state_t state;

  logic [SLOTS_W-1:0]    wheel_slots;
  logic [SLOTS_W-1:0]    slots;
  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] cancelled;

  entry_t                mem [NUM_TIMERS];
  entry_t                mem_rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_addr;
  entry_t                mem_wd;

  logic [IDX_W-1:0]      idx;
  logic [ID_W-1:0]       ack_id;
  logic                  ack_present;
  logic [DELAY_W-1:0]    div_q;
  logic [SLOTS_W-1:0]    div_rem;
  logic [3:0]            div_cnt;
  logic                  pend_valid;
  logic [ID_W-1:0]       pend_id;
  logic                  pend_cb;

  logic                  cmd_fire;
  logic [IDX_W-1:0]      cmd_idx;
  logic                  cmd_id_ok;
  logic                  evt_free;
  logic                  evt_load;
  logic [SLOTS_W:0]      div_trial;
  logic [SLOTS_W-1:0]    div_rem_next;
  logic [SLOTS_W-1:0]    fresh;
  logic [SLOTS_W-1:0]    ticks_dec;
  logic                  tick_hit;
  logic                  tupd_go;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign cmd_idx   = IDX_W'(cmd.timer_id);
  assign cmd_id_ok = ({3'b000, cmd.timer_id} < ID_LIMIT);
  assign evt_free  = !evt_valid || !evt_stall;
  assign slots     = (wheel_slots == '0) ? SLOTS_W'(1) : wheel_slots;

  assign div_trial    = {div_rem, div_q[DELAY_W-1]};
  assign div_rem_next = (div_trial >= {1'b0, slots}) ?
                        SLOTS_W'(div_trial - {1'b0, slots}) : div_trial[SLOTS_W-1:0];

  assign fresh     = (mem_rdata.delay_mod == '0) ? slots : mem_rdata.delay_mod;
  assign ticks_dec = mem_rdata.ticks - SLOTS_W'(1);
  assign tick_hit  = (ticks_dec == '0);
  assign tupd_go   = !tick_hit || !pend_valid || evt_free;
  assign evt_load  = (((state == S_ACK) || (state == S_TEND)) && evt_free) ||
                     ((state == S_TUPD) && tupd_go && tick_hit && pend_valid);

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = idx;
    mem_wd   = mem_rdata;
    unique case (state)
      S_IDLE: begin
        mem_addr = cmd_idx;
        mem_re   = cmd_fire && cmd_id_ok && (op_t'(cmd.op) == OP_REFRESH) &&
                   active[cmd_idx];
      end
      S_DIV: begin
        mem_we           = (div_cnt == DIV_LAST);
        mem_wd.delay_mod = div_rem_next;
        mem_wd.ticks     = (div_rem_next == '0) ? slots : div_rem_next;
      end
      S_RD: begin
        mem_we       = 1'b1;
        mem_wd.ticks = (fresh > mem_rdata.ticks) ? fresh : mem_rdata.ticks;
      end
      S_TSCAN: begin
        mem_re = active[idx];
      end
      S_TUPD: begin
        mem_we       = tupd_go;
        mem_wd.ticks = ticks_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_slots <= WHEEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wheel_slots <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      cancelled  <= '0;
      evt_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall && !evt_load) begin
        evt_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            idx         <= (op_t'(cmd.op) == OP_TICK) ? '0 : cmd_idx;
            ack_id      <= cmd.timer_id;
            ack_present <= cmd_id_ok &&
                           ((op_t'(cmd.op) == OP_ADD) || active[cmd_idx]);
            div_q       <= cmd.delay;
            div_rem     <= '0;
            div_cnt     <= '0;
            pend_valid  <= 1'b0;
            if (op_t'(cmd.op) == OP_TICK) begin
              state <= S_TSCAN;
            end else if (cmd_id_ok && (op_t'(cmd.op) == OP_ADD)) begin
              state <= S_DIV;
            end else if (mem_re) begin
              state <= S_RD;
            end else begin
              if (cmd_id_ok && (op_t'(cmd.op) == OP_CANCEL) && active[cmd_idx]) begin
                cancelled[cmd_idx] <= 1'b1;
              end
              state <= S_ACK;
            end
          end
        end
        S_DIV: begin
          div_rem <= div_rem_next;
          div_q   <= {div_q[DELAY_W-2:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == DIV_LAST) begin
            active[idx]    <= 1'b1;
            cancelled[idx] <= 1'b0;
            state          <= S_ACK;
          end
        end
        S_RD: begin
          state <= S_ACK;
        end
        S_ACK: begin
          if (evt_free) begin
            evt_valid <= 1'b1;
            evt       <= '{event_kind: EVT_ACK, expired_id: ack_id, callback_run: 1'b0,
                           present: ack_present, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_TSCAN: begin
          if (active[idx]) begin
            state <= S_TUPD;
          end else if (idx == IDX_LAST) begin
            state <= S_TEND;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_TUPD: begin
          if (tupd_go) begin
            if (tick_hit) begin
              active[idx]    <= 1'b0;
              cancelled[idx] <= 1'b0;
              pend_valid     <= 1'b1;
              pend_id        <= ID_W'(idx);
              pend_cb        <= !cancelled[idx];
              if (pend_valid) begin
                evt_valid <= 1'b1;
                evt       <= '{event_kind: EVT_EXPIRY, expired_id: pend_id,
                               callback_run: pend_cb, present: 1'b0, last: 1'b0};
              end
            end
            if (idx == IDX_LAST) begin
              state <= S_TEND;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_TSCAN;
            end
          end
        end
        S_TEND: begin
          if (evt_free) begin
            evt_valid <= 1'b1;
            if (pend_valid) begin
              evt <= '{event_kind: EVT_EXPIRY, expired_id: pend_id,
                       callback_run: pend_cb, present: 1'b0, last: 1'b1};
            end else begin
              evt <= '{event_kind: EVT_ACK, expired_id: '0, callback_run: 1'b0,
                       present: 1'b0, last: 1'b1};
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the timing wheel timeout table against a cycle-free predictor of its
// timer entries. A short directed table covers reset state, extreme delays,
// every command, cancelled and re-added timers and simultaneous expiries;
// random commands then run under several wheel sizes, with random idling on
// both sides, one long result hold-off and drain points.
// ----------------------------------------------------------------------------
module testbench;

  import twt_pkg::*;

  localparam int NUM_TIMERS    = NUM_TIMERS_DEF;
  localparam int TAIL_CYCLES   = 2 * NUM_TIMERS + 8;
  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASE_COUNT   = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DELAY_MAX     = (1 << DELAY_W) - 1;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    cmd_t cmd;
    logic checked;
    evt_t want;
  } directed_row_t;

  localparam evt_t NO_EVT = '0;
  localparam int DIRECTED_COUNT = 25;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{OP_QUERY,   4'd0,  12'd0},    1'b1, '{EVT_ACK, 4'd0,  1'b0, 1'b0, 1'b1}},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b1, '{EVT_ACK, 4'd0,  1'b0, 1'b0, 1'b1}},
    '{'{OP_ADD,     4'd0,  12'd0},    1'b1, '{EVT_ACK, 4'd0,  1'b0, 1'b1, 1'b1}},
    '{'{OP_ADD,     4'd15, 12'd4095}, 1'b1, '{EVT_ACK, 4'd15, 1'b0, 1'b1, 1'b1}},
    '{'{OP_ADD,     4'd1,  12'd1},    1'b1, '{EVT_ACK, 4'd1,  1'b0, 1'b1, 1'b1}},
    '{'{OP_ADD,     4'd2,  12'd2},    1'b1, '{EVT_ACK, 4'd2,  1'b0, 1'b1, 1'b1}},
    '{'{OP_CANCEL,  4'd2,  12'd0},    1'b1, '{EVT_ACK, 4'd2,  1'b0, 1'b1, 1'b1}},
    '{'{OP_REFRESH, 4'd1,  12'd0},    1'b1, '{EVT_ACK, 4'd1,  1'b0, 1'b1, 1'b1}},
    '{'{OP_CANCEL,  4'd5,  12'd0},    1'b1, '{EVT_ACK, 4'd5,  1'b0, 1'b0, 1'b1}},
    '{'{OP_REFRESH, 4'd6,  12'd0},    1'b1, '{EVT_ACK, 4'd6,  1'b0, 1'b0, 1'b1}},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_QUERY,   4'd2,  12'd0},    1'b1, '{EVT_ACK, 4'd2,  1'b0, 1'b0, 1'b1}},
    '{'{OP_SPARE_A, 4'd15, 12'd4095}, 1'b0, NO_EVT},
    '{'{OP_SPARE_C, 4'd3,  12'd4095}, 1'b0, NO_EVT},
    '{'{OP_ADD,     4'd3,  12'd600},  1'b0, NO_EVT},
    '{'{OP_ADD,     4'd0,  12'd3},    1'b0, NO_EVT},
    '{'{OP_ADD,     4'd4,  12'd3},    1'b0, NO_EVT},
    '{'{OP_CANCEL,  4'd4,  12'd0},    1'b0, NO_EVT},
    '{'{OP_REFRESH, 4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_TICK,    4'd0,  12'd0},    1'b0, NO_EVT},
    '{'{OP_SPARE_B, 4'd9,  12'd2730}, 1'b0, NO_EVT},
    '{'{OP_REFRESH, 4'd15, 12'd0},    1'b0, NO_EVT}
  };

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  cmd_t               cmd;
  logic               evt_valid;
  logic               evt_stall;
  evt_t               evt;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLOTS_W-1:0] cfg_data;

  logic               shadow_active    [NUM_TIMERS];
  logic               shadow_cancelled [NUM_TIMERS];
  logic [SLOTS_W-1:0] shadow_delay     [NUM_TIMERS];
  logic [SLOTS_W-1:0] shadow_ticks     [NUM_TIMERS];
  logic [SLOTS_W-1:0] shadow_slots;

  evt_t step_events[$];
  evt_t expected_events[$];
  evt_t arrived_want;
  int   mismatch_count;
  int   cycle_count;
  bit   hold_request;
  bit   hold_started;
  int   hold_left;
  int   stall_left;
  int   free_left;

  timing_wheel_timeouts #(
    .NUM_TIMERS(NUM_TIMERS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_timer_table();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      shadow_active[i] = 1'b0;
      shadow_cancelled[i] = 1'b0;
      shadow_delay[i] = '0;
      shadow_ticks[i] = '0;
    end
    shadow_slots = WHEEL_RESET;
  endfunction

  // Works out the result beats of one command and updates the timer table.
  function automatic void predict_timer_events(input cmd_t c);
    int           id;
    int           slots;
    int           fresh;
    logic         in_range;
    evt_t         beat;
    id = int'(c.timer_id);
    in_range = id < NUM_TIMERS;
    slots = (shadow_slots == 0) ? 1 : int'(shadow_slots);
    step_events.delete();
    if (c.op == OP_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (shadow_active[i]) begin
          shadow_ticks[i] = shadow_ticks[i] - 1'b1;
          if (shadow_ticks[i] == 0) begin
            shadow_active[i] = 1'b0;
            beat = '0;
            beat.event_kind = EVT_EXPIRY;
            beat.expired_id = i[ID_W-1:0];
            beat.callback_run = !shadow_cancelled[i];
            shadow_cancelled[i] = 1'b0;
            step_events = {step_events, beat};
          end
        end
      end
      if (step_events.size() == 0) step_events = {step_events, NO_EVT};
    end else begin
      if (in_range) begin
        case (c.op)
          OP_ADD: begin
            fresh = int'(c.delay) % slots;
            shadow_delay[id] = fresh[SLOTS_W-1:0];
            shadow_ticks[id] = (fresh == 0) ? slots[SLOTS_W-1:0] : fresh[SLOTS_W-1:0];
            shadow_active[id] = 1'b1;
            shadow_cancelled[id] = 1'b0;
          end
          OP_REFRESH: begin
            if (shadow_active[id]) begin
              fresh = (shadow_delay[id] == 0) ? slots : int'(shadow_delay[id]);
              if (fresh > int'(shadow_ticks[id])) shadow_ticks[id] = fresh[SLOTS_W-1:0];
            end
          end
          OP_CANCEL: begin
            if (shadow_active[id]) shadow_cancelled[id] = 1'b1;
          end
          default: begin
          end
        endcase
      end
      beat = '0;
      beat.event_kind = EVT_ACK;
      beat.expired_id = c.timer_id;
      beat.present = in_range && shadow_active[id];
      step_events = {step_events, beat};
    end
    step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 30) c.op = OP_ADD;
    else if (r < 42) c.op = OP_REFRESH;
    else if (r < 52) c.op = OP_CANCEL;
    else if (r < 80) c.op = OP_TICK;
    else if (r < 93) c.op = OP_QUERY;
    else c.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    c.timer_id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    if ($urandom_range(0, 9) < 7) c.delay = DELAY_W'($urandom_range(0, 12));
    else c.delay = DELAY_W'($urandom_range(0, DELAY_MAX));
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_command(input cmd_t c, input logic checked, input evt_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_timer_events(c);
    if (checked) begin
      expected_events = {expected_events, want};
    end else begin
      foreach (step_events[i]) expected_events = {expected_events, step_events[i]};
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_wheel_slots(input logic [SLOTS_W-1:0] slots);
    cfg_data <= slots;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_slots = slots;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      evt_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      evt_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      evt_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      free_left = $urandom_range(0, 30);
      evt_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) begin
      if (expected_events.size() == 0) begin
        $error("result beat with nothing expected: expired_id %0d", evt.expired_id);
        mismatch_count++;
      end else begin
        arrived_want = expected_events.pop_front();
        check_field("event_kind", arrived_want.event_kind, evt.event_kind);
        check_field("expired_id", arrived_want.expired_id, evt.expired_id);
        check_field("callback_run", arrived_want.callback_run, evt.callback_run);
        check_field("present", arrived_want.present, evt.present);
        check_field("last", arrived_want.last, evt.last);
      end
    end
  end

  initial begin
    logic [SLOTS_W-1:0] phase_slots [PHASE_COUNT];
    int                 phase_items;
    int                 waited;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    evt_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_request = 1'b0;
    hold_started = 1'b0;
    hold_left = 0;
    stall_left = 0;
    free_left = 0;
    reset_timer_table();
    phase_slots[0] = 10'd1023;
    phase_slots[1] = 10'd0;
    phase_slots[2] = 10'd1;
    phase_slots[3] = 10'd7;
    phase_slots[4] = SLOTS_W'($urandom_range(2, 1022));
    phase_slots[5] = WHEEL_RESET;
    phase_items = RANDOM_ITEMS / PHASE_COUNT;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].checked, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      write_wheel_slots(phase_slots[p]);
      for (int n = 0; n < phase_items; n++) begin
        if (p == 2 && n == 10) hold_request = 1'b1;
        if (p == 3 && n == phase_items / 2) begin
          cmd_valid <= 1'b0;
          while (expected_events.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        send_command(random_command(), 1'b0, NO_EVT);
      end
    end

    cmd_valid <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
